/* sv/fps_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fps_pkg
// Shared types and constants for the function prologue scanner.
// ----------------------------------------------------------------------------
package fps_pkg;

   // width of the internal scan address counter (16 to 64)
   localparam int ADDR_WIDTH = 32;

   // scan phase codes
   localparam logic [2:0] PH_IDLE  = 3'd0;
   localparam logic [2:0] PH_SETHI = 3'd1;
   localparam logic [2:0] PH_ADD   = 3'd2;
   localparam logic [2:0] PH_SAVE  = 3'd3;
   localparam logic [2:0] PH_STORE = 3'd4;

   // no sethi destination recorded
   localparam logic [5:0] DEST_NONE = 6'd32;

   // instruction field codes
   localparam logic [1:0] OP_BRANCH = 2'd0;
   localparam logic [1:0] OP_ARITH  = 2'd2;
   localparam logic [1:0] OP_MEM    = 2'd3;
   localparam logic [2:0] OP2_SETHI = 3'd4;
   localparam logic [5:0] OP3_SAVE  = 6'h3c;
   localparam logic [5:0] OP3_STORE_MASK = 6'h3c;
   localparam logic [5:0] OP3_STORE      = 6'h04;
   localparam logic [4:0] RD_IN_MASK  = 5'h18;
   localparam logic [4:0] RD_G1       = 5'd1;
   localparam logic [4:0] RS1_FP      = 5'd30;
   localparam logic [12:0] STORE_OFS_LO = 13'h044;
   localparam logic [12:0] STORE_OFS_HI = 13'h05b;  // exclusive

   typedef struct packed {
      logic [2:0]            phase;
      logic [5:0]            sethi_dest;
      logic [ADDR_WIDTH-1:0] addr;
   } scan_state_type;

   typedef struct packed {
      scan_state_type next;
      logic           emit;
      logic [31:0]    end_address;
   } classify_type;

endpackage : fps_pkg
`default_nettype wire

/* sv/function_prologue_scanner.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// function_prologue_scanner
// Finds the end of a function prologue in a stream of instruction words.
// ----------------------------------------------------------------------------
// Usage:
//   Feed instruction words in address order on the req_ channel. Set
//   req_tuser on the first word of a scan; req_tdata then also carries the
//   start address. Words with req_tuser low and no scan active are dropped.
//   A word that matches no remaining prologue step (sethi, add, save, store
//   run) ends the scan, and its address comes out as one word on rsp_.
//   Words that stay inside the prologue give no result.
// Timing:
//   One word per cycle sustained while the skid stage is empty. A word passes
//   the input register, then its result the result register, before rsp_tvalid.
// Stall:
//   A stalled rsp_ side holds its word; one more result fits in the skid
//   stage, after which req_tready drops until the result register drains.
// Reset:
//   Synchronous, active high. No scan active, both channels empty.
// ----------------------------------------------------------------------------
module function_prologue_scanner (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,   // [31:0] start_address, [63:32] insn
   input  wire logic        req_tuser,   // [0] first
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata    // [31:0] end_address
);
   import fps_pkg::*;

   // input register
   logic        in_valid_ff, in_valid_in;
   logic        in_first_ff;
   logic [31:0] in_start_ff;
   logic [31:0] in_insn_ff;

   // scan state
   scan_state_type state_ff, state_in;

   classify_type cls;
   logic         skid_full;
   logic         process_en;

   // the held word is processed unless the skid stage is occupied
   assign process_en  = in_valid_ff && !skid_full;
   assign req_tready  = !in_valid_ff || process_en;
   assign in_valid_in = req_tready ? req_tvalid : in_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_tready) begin
         in_first_ff <= req_tuser;
         in_start_ff <= req_tdata[31:0];
         in_insn_ff  <= req_tdata[63:32];
      end
   end

   fps_classify u_classify (
      .first         (in_first_ff),
      .start_address (in_start_ff),
      .insn          (in_insn_ff),
      .cur           (state_ff),
      .result        (cls)
   );

   assign state_in = process_en ? cls.next : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase      <= PH_IDLE;
         state_ff.sethi_dest <= DEST_NONE;
         state_ff.addr       <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

   fps_out_skid u_out (
      .clock      (clock),
      .reset      (reset),
      .push_valid (process_en && cls.emit),
      .push_data  (cls.end_address),
      .skid_full  (skid_full),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   a_emit_goes_idle: assert property (@(posedge clock) disable iff (reset)
      (process_en && cls.emit) |=> (state_ff.phase == PH_IDLE))
      else $error("scan still active after end address emitted");

   a_step_advances: assert property (@(posedge clock) disable iff (reset)
      (process_en && !in_first_ff && !cls.emit && state_ff.phase != PH_IDLE &&
       state_ff.phase <= PH_STORE)
      |=> (state_ff.addr == $past(state_ff.addr) + ADDR_WIDTH'(4)))
      else $error("scan address did not advance by one word");

   a_state_holds_on_stall: assert property (@(posedge clock) disable iff (reset)
      !process_en |=> $stable(state_ff))
      else $error("scan state changed without a processed word");

endmodule : function_prologue_scanner
`default_nettype wire

/* sv/fps_classify.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fps_classify
// Matches one instruction word against the prologue steps and computes the
// next scan state and the optional end address.
// ----------------------------------------------------------------------------
module fps_classify (
   input  wire logic                    first,
   input  wire logic [31:0]             start_address,
   input  wire logic [31:0]             insn,
   input  wire fps_pkg::scan_state_type cur,
   output fps_pkg::classify_type        result
);
   import fps_pkg::*;

   logic [1:0]  op;
   logic [4:0]  rd;
   logic [2:0]  op2;
   logic [5:0]  op3;
   logic [4:0]  rs1;
   logic        imm;
   logic [12:0] simm13;

   scan_state_type st;
   logic           m_sethi, m_add, m_save, m_store;
   logic [ADDR_WIDTH-1:0] addr_next;

   assign op     = insn[31:30];
   assign rd     = insn[29:25];
   assign op2    = insn[24:22];
   assign op3    = insn[24:19];
   assign rs1    = insn[18:14];
   assign imm    = insn[13];
   assign simm13 = insn[12:0];

   assign m_sethi = (op == OP_BRANCH) && (op2 == OP2_SETHI);
   assign m_add   = (op == OP_ARITH) && imm &&
                    ((rd == RD_G1) || ({1'b0, rd} == st.sethi_dest));
   assign m_save  = (op == OP_ARITH) && (op3 == OP3_SAVE);
   assign m_store = (op == OP_MEM) && ((op3 & OP3_STORE_MASK) == OP3_STORE) &&
                    ((rd & RD_IN_MASK) == RD_IN_MASK) && imm && (rs1 == RS1_FP) &&
                    (simm13 >= STORE_OFS_LO) && (simm13 < STORE_OFS_HI);

   // a new scan overrides whatever was in progress
   always_comb begin
      if (first) begin
         st.phase      = PH_SETHI;
         st.sethi_dest = DEST_NONE;
         st.addr       = ADDR_WIDTH'(start_address);
      end else begin
         st = cur;
      end
   end

   assign addr_next = st.addr + ADDR_WIDTH'(4);

   always_comb begin
      result.next        = st;
      result.emit        = 1'b0;
      result.end_address = 32'(st.addr);
      unique case (st.phase)
         PH_SETHI, PH_ADD, PH_SAVE, PH_STORE: begin
            result.next.addr = addr_next;
            if ((st.phase == PH_SETHI) && m_sethi) begin
               result.next.phase      = PH_ADD;
               result.next.sethi_dest = {1'b0, rd};
            end else if ((st.phase <= PH_ADD) && m_add) begin
               result.next.phase = PH_SAVE;
            end else if ((st.phase <= PH_SAVE) && m_save) begin
               result.next.phase = PH_STORE;
            end else if (m_store) begin
               result.next.phase = PH_STORE;
            end else begin
               // prologue over: report this word's address
               result.next.phase = PH_IDLE;
               result.next.addr  = st.addr;
               result.emit       = 1'b1;
            end
         end
         default: begin
            // idle: word ignored
            result.next = st;
         end
      endcase
   end

endmodule : fps_classify
`default_nettype wire

/* sv/fps_out_skid.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fps_out_skid
// Result register with a one-word skid stage toward the result channel.
// ----------------------------------------------------------------------------
module fps_out_skid (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push_valid,
   input  wire logic [31:0] push_data,
   output logic             skid_full,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata
);
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_data_ff, rsp_data_in;
   logic        skid_valid_ff, skid_valid_in;
   logic [31:0] skid_data_ff, skid_data_in;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!rsp_valid_ff || rsp_tready) begin
         if (skid_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            rsp_valid_in = push_valid;
            rsp_data_in  = push_data;
         end
      end else if (push_valid) begin
         skid_valid_in = 1'b1;
         skid_data_in  = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign skid_full  = skid_valid_ff;

   a_skid_behind_rsp: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid holds a word while result register is empty");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> !push_valid)
      else $error("result pushed while skid stage full");

   a_skid_drains_first: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && rsp_tready) |=> (rsp_valid_ff && rsp_data_ff == $past(skid_data_ff)))
      else $error("skid word not moved to result register");

endmodule : fps_out_skid
`default_nettype wire
